/* src/assert_macros.svh */
// Assertion helpers for a module that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define SID_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// A condition that, once seen, implies another in the next cycle.
`define SID_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* src/sid_pkg.sv */
package sid_pkg;

    // Fixed field widths of the request and response, and the default capacity.
    localparam int KEY_WIDTH    = 32;
    localparam int OCC_WIDTH    = 5;
    localparam int CAPACITY_DEF = 16;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_sid_cmd;

    typedef enum logic [1:0] {
        ST_NOT_DONE = 2'd0,
        ST_DONE     = 2'd1,
        ST_FULL     = 2'd2
    } t_sid_status;

    typedef struct packed {
        t_sid_cmd               command;
        logic [KEY_WIDTH-1:0]   key;
    } t_sid_req;

    typedef struct packed {
        t_sid_status            status;
        logic [OCC_WIDTH-1:0]   occupancy;
    } t_sid_rsp;

    // Shift controls broadcast to every cell of the chain.
    typedef struct packed {
        logic shift_in;
        logic shift_out;
    } t_sid_ctl;

endpackage

/* src/sid_cell.sv */
module sid_cell
    import sid_pkg::*;
#(
    parameter int CW  = 5,
    parameter int IDX = 0
) (
    input  logic                 i_clk,
    input  t_sid_ctl             i_ctl,
    input  logic [KEY_WIDTH-1:0] i_key,
    input  logic [CW-1:0]        i_count,
    input  logic [KEY_WIDTH-1:0] i_left_entry,
    input  logic                 i_left_lt,
    input  logic [KEY_WIDTH-1:0] i_right_entry,
    output logic [KEY_WIDTH-1:0] o_entry,
    output logic                 o_lt,
    output logic                 o_eq
);

    localparam logic [CW-1:0] POS = CW'(IDX);

    logic [KEY_WIDTH-1:0] r_entry;
    logic [KEY_WIDTH-1:0] n_entry;
    logic                 w_occupied;

    // Compare the broadcast key against the entry held here.
    assign w_occupied = (POS < i_count);
    assign o_lt       = w_occupied && (r_entry < i_key);
    assign o_eq       = w_occupied && (r_entry == i_key);
    assign o_entry    = r_entry;

    // Cells at or past the insert point take the key or their left
    // neighbour's entry; on removal they take their right neighbour's.
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.shift_in && !o_lt) begin
            n_entry = i_left_lt ? i_key : i_left_entry;
        end else if (i_ctl.shift_out && !o_lt) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

/* src/sorted_id_set.sv */
// Sorted set of unique IDs held in a chain of compare-and-shift cells.
// Requests enter on the input channel (i_in_valid, o_in_stall, i_in_data):
// a command (insert, lookup, remove, clear) and a key. Every request gives
// exactly one response on the output channel (o_out_valid, i_out_stall,
// o_out_data) carrying a status and the number of IDs held afterwards.
// A request is first registered; then every cell compares the key in
// parallel and, as the request executes, the chain shifts by one place to
// open or close a gap and the response is registered. One request is taken
// per cycle as long as the receiver keeps up: the single execute stage sets
// that rate, and the next request sees the set as the previous one left it.
// When the receiver stalls, the response register holds and the pending
// request waits in its stage; o_in_stall rises once that stage is occupied.
// Reset empties the set at once (the count clears; entry contents are
// left as they are and are not read until written) and drops any request
// or response in flight. Occupancy is reported in five bits.
module sorted_id_set
    import sid_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_sid_req i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_sid_rsp o_out_data
);

`include "assert_macros.svh"

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    t_sid_req             r_req;
    logic                 r_req_valid;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    t_sid_rsp             r_rsp;
    logic                 r_rsp_valid;
    t_sid_status          w_status;
    t_sid_ctl             w_ctl;
    logic                 w_fire;
    logic                 w_present;
    logic                 w_full;
    logic [KEY_WIDTH-1:0] w_entry [CAPACITY];
    logic [CAPACITY-1:0]  w_lt;
    logic [CAPACITY-1:0]  w_eq;

    // The request executes when the response register is free or its response is being taken.
    assign w_fire     = r_req_valid && (!r_rsp_valid || !i_out_stall);
    assign o_in_stall = r_req_valid && !w_fire;
    assign w_present  = |w_eq;
    assign w_full     = (r_count == FULL_COUNT);

    // Chain of cells, each fed by its neighbours.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_WIDTH-1:0] w_left_entry;
        logic                 w_left_lt;
        logic [KEY_WIDTH-1:0] w_right_entry;

        if (g == 0) begin : g_first
            assign w_left_entry = r_req.key;
            assign w_left_lt    = 1'b1;
        end else begin : g_inner
            assign w_left_entry = w_entry[g-1];
            assign w_left_lt    = w_lt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right_entry = w_entry[g];
        end else begin : g_body
            assign w_right_entry = w_entry[g+1];
        end

        sid_cell #(
            .CW  (CW),
            .IDX (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_key         (r_req.key),
            .i_count       (r_count),
            .i_left_entry  (w_left_entry),
            .i_left_lt     (w_left_lt),
            .i_right_entry (w_right_entry),
            .o_entry       (w_entry[g]),
            .o_lt          (w_lt[g]),
            .o_eq          (w_eq[g])
        );
    end

    // Command decode: status, new count and the shift controls.
    always_comb begin
        w_status        = ST_NOT_DONE;
        n_count         = r_count;
        w_ctl.shift_in  = 1'b0;
        w_ctl.shift_out = 1'b0;
        case (r_req.command)
            CMD_INSERT: begin
                if (w_present) begin
                    w_status = ST_NOT_DONE;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_status       = ST_DONE;
                    n_count        = r_count + 1'b1;
                    w_ctl.shift_in = w_fire;
                end
            end
            CMD_LOOKUP: begin
                w_status = w_present ? ST_DONE : ST_NOT_DONE;
            end
            CMD_REMOVE: begin
                if (w_present) begin
                    w_status        = ST_DONE;
                    n_count         = r_count - 1'b1;
                    w_ctl.shift_out = w_fire;
                end
            end
            CMD_CLEAR: begin
                w_status = ST_DONE;
                n_count  = '0;
            end
            default: begin
                w_status = ST_NOT_DONE;
            end
        endcase
    end

    // Request stage and entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (w_fire) begin
                r_count <= n_count;
            end
            if (!o_in_stall) begin
                r_req_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_req <= i_in_data;
        end
    end

    // Response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (w_fire) begin
            r_rsp_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_rsp.status    <= w_status;
            r_rsp.occupancy <= OCC_WIDTH'(n_count);
        end
    end

    assign o_out_valid = r_rsp_valid;
    assign o_out_data  = r_rsp;

    // The count never passes the capacity of the chain.
    `SID_ASSERT(a_count_bound, r_count <= FULL_COUNT, "entry count above capacity")
    // A refusal is only given when every cell is in use.
    `SID_ASSERT(a_full_only_when_full, !(w_fire && w_status == ST_FULL) || w_full,
        "insert refused while the set has room")
    // A successful insert grows the set by exactly one entry.
    `SID_ASSERT_NEXT(a_insert_grows, w_ctl.shift_in, r_count == $past(r_count) + 1'b1,
        "insert did not add one entry")
    // A clear empties the set.
    `SID_ASSERT_NEXT(a_clear_empties, w_fire && r_req.command == CMD_CLEAR, r_count == '0,
        "clear left entries behind")

endmodule

/* sim/sorted_id_set_test.sv */
module sorted_id_set_test;
    import sid_pkg::*;

    // Tracks the expected contents of the set and checks each response.
    class id_set_scoreboard;
        logic [KEY_WIDTH-1:0] held_ids [CAPACITY_DEF];
        int unsigned          held_count = 0;
        t_sid_rsp             awaited_rsp [$];
        int unsigned          mismatches = 0;

        // Applies one command to the tracked set and returns its response.
        function t_sid_rsp apply_command(t_sid_req req);
            int unsigned pos;
            int unsigned i;
            bit          present;
            t_sid_rsp    rsp;
            pos = 0;
            while (pos < held_count && held_ids[pos] < req.key)
                pos++;
            present = (pos < held_count) && (held_ids[pos] == req.key);
            rsp.status = ST_NOT_DONE;
            case (req.command)
                CMD_INSERT: begin
                    if (present) begin
                        rsp.status = ST_NOT_DONE;
                    end else if (held_count >= CAPACITY_DEF) begin
                        rsp.status = ST_FULL;
                    end else begin
                        for (i = held_count; i > pos; i--)
                            held_ids[i] = held_ids[i-1];
                        held_ids[pos] = req.key;
                        held_count++;
                        rsp.status = ST_DONE;
                    end
                end
                CMD_LOOKUP: begin
                    rsp.status = present ? ST_DONE : ST_NOT_DONE;
                end
                CMD_REMOVE: begin
                    if (present) begin
                        for (i = pos; i + 1 < held_count; i++)
                            held_ids[i] = held_ids[i+1];
                        held_count--;
                        rsp.status = ST_DONE;
                    end
                end
                CMD_CLEAR: begin
                    held_count = 0;
                    rsp.status = ST_DONE;
                end
            endcase
            rsp.occupancy = OCC_WIDTH'(held_count);
            return rsp;
        endfunction

        function void note_request(t_sid_req req);
            awaited_rsp.push_back(apply_command(req));
        endfunction

        function void check_response(t_sid_rsp got);
            t_sid_rsp want;
            if (awaited_rsp.size() == 0) begin
                $display("%0t: response with none awaited, expected nothing, actual %0d/%0d",
                         $time, got.status, got.occupancy);
                mismatches++;
                return;
            end
            want = awaited_rsp.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.status, got.status);
                mismatches++;
            end
            if (got.occupancy !== want.occupancy) begin
                $display("%0t: occupancy mismatch, expected %0d, actual %0d",
                         $time, want.occupancy, got.occupancy);
                mismatches++;
            end
        endfunction

        function int unsigned outstanding();
            return awaited_rsp.size();
        endfunction
    endclass

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    t_sid_req in_data = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    t_sid_rsp out_data;

    // Shared controls between the request sender and the response receiver.
    bit          steady_flow = 1'b0;
    int unsigned hold_request = 0;

    id_set_scoreboard tracker = new();

    logic [KEY_WIDTH-1:0] key_pool [24];
    int unsigned          pool_size;

    sorted_id_set DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // Observe both channels at each edge, using the values from before it.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall)
                tracker.note_request(in_data);
            if (out_valid && !out_stall)
                tracker.check_response(out_data);
        end
    end

    // Response receiver: random stalls, a quiet mode and one long hold-off.
    initial begin
        int unsigned wait_cycles;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            if (hold_request > 0) begin
                wait_cycles = hold_request;
                hold_request = 0;
            end else begin
                wait_cycles = steady_flow ? 0 : $urandom_range(0, 19);
            end
            if (wait_cycles > 0) begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    function automatic t_sid_req make_request(t_sid_cmd cmd, logic [KEY_WIDTH-1:0] key);
        t_sid_req req;
        req.command = cmd;
        req.key     = key;
        return req;
    endfunction

    // Offers one request after a random gap and returns once it is taken.
    task automatic send_request(t_sid_req req);
        int unsigned gap;
        gap = steady_flow ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (tracker.outstanding() != 0);
    endtask

    // Fresh set of candidate keys, either scattered or clustered near one base.
    task automatic refresh_pool();
        int unsigned          j;
        logic [KEY_WIDTH-1:0] base;
        bit                   clustered;
        pool_size = $urandom_range(3, 24);
        base      = $urandom;
        clustered = $urandom_range(0, 1);
        for (j = 0; j < 24; j++)
            key_pool[j] = clustered ? (base ^ (32'd1 << $urandom_range(0, 31))) : $urandom;
        if ($urandom_range(0, 1)) begin
            key_pool[0] = '0;
            key_pool[1] = '1;
        end
    endtask

    task automatic send_random(int unsigned ins_pct, int unsigned clr_pct);
        int unsigned          r;
        t_sid_cmd             cmd;
        logic [KEY_WIDTH-1:0] key;
        r = $urandom_range(0, 99);
        if (r < clr_pct)
            cmd = CMD_CLEAR;
        else if (r < clr_pct + ins_pct)
            cmd = CMD_INSERT;
        else if (r < clr_pct + ins_pct + 20)
            cmd = CMD_LOOKUP;
        else
            cmd = CMD_REMOVE;
        if ($urandom_range(0, 9) == 0)
            key = $urandom;
        else
            key = key_pool[$urandom_range(0, pool_size - 1)];
        send_request(make_request(cmd, key));
    endtask

    // Main stimulus: reset, directed cases, then random phases.
    initial begin
        int unsigned j;
        int unsigned phase;
        int unsigned n;
        int unsigned ins_pct;
        int unsigned clr_pct;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Empty set, both extremes of the key, duplicates and a full set.
        send_request(make_request(CMD_CLEAR,  32'd5));
        send_request(make_request(CMD_LOOKUP, 32'd5));
        send_request(make_request(CMD_REMOVE, 32'd5));
        send_request(make_request(CMD_INSERT, '0));
        send_request(make_request(CMD_INSERT, '1));
        send_request(make_request(CMD_INSERT, '0));
        send_request(make_request(CMD_LOOKUP, '1));
        send_request(make_request(CMD_REMOVE, '0));
        for (j = 1; j < 16; j++)
            send_request(make_request(CMD_INSERT,
                {4'((j * 7) % 16), 28'h0} ^ 32'h0A5A_5A5A));
        send_request(make_request(CMD_INSERT, 32'd5));
        send_request(make_request(CMD_INSERT, '1));
        send_request(make_request(CMD_LOOKUP, 32'h7A5A_5A5A));
        send_request(make_request(CMD_REMOVE, 32'h7A5A_5A5A));
        send_request(make_request(CMD_CLEAR,  '0));
        wait_drained();

        // Random phases of well-formed traffic over a small key pool.
        for (phase = 0; phase < 15; phase++) begin
            refresh_pool();
            steady_flow = (phase % 4 == 1) || (phase == 2);
            ins_pct     = $urandom_range(30, 60);
            clr_pct     = $urandom_range(0, 1) ? 0 : 3;
            // Hold the receiver off for a long stretch while requests keep coming.
            if (phase == 2)
                hold_request = 60;
            for (n = 0; n < 40; n++)
                send_random(ins_pct, clr_pct);
            if (phase == 5 || $urandom_range(0, 2) == 0)
                wait_drained();
        end
        steady_flow = 1'b0;

        wait_drained();
        repeat (10) @(posedge clk);
        if (tracker.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #(12 * 400000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/sid_pkg.sv
src/sid_cell.sv
src/sorted_id_set.sv
sim/sorted_id_set_test.sv
